>>> rtl/lfsa_pkg.sv
// Shared types and constants of the LIFO free-list slot allocator.
// Used by every module of the block but lfsa_ram; depends on nothing else.
package lfsa_pkg;

   localparam int SLOT_NUM_W = 9;   // width of a request's slot number
   localparam int COUNT_W    = 9;   // width of the slot count register
   localparam int ADDR_W     = 48;  // width of byte addresses
   localparam int GRANT_W    = 8;   // width of the granted slot id
   localparam int CSR_DATA_W = 48;  // widest configuration register

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_NONE_FREE = 2'd1,
      ST_FREED     = 2'd2,
      ST_IGNORED   = 2'd3
   } status_type;

   typedef enum logic {
      REG_SLOTS_IN_USE = 1'b0,
      REG_BASE_ADDRESS = 1'b1
   } csr_index_type;

   // One classified request as it waits between the front and the back.
   typedef struct packed {
      op_type                  op;
      logic [SLOT_NUM_W-1:0]   slot;
      logic                    in_range;
   } item_type;

endpackage

>>> rtl/lfsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependency.
module lfsa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lfsa_front.sv
// Request front end: accepts request beats and classifies them for the back end.
// Depends on lfsa_pkg.
module lfsa_front import lfsa_pkg::*; #(
   parameter int HEAD_W = 9
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [8:0] slot_number
   input  logic                  req_tuser,   // [0] operation
   input  logic [HEAD_W-1:0]     count,
   input  logic                  q_full,
   output logic                  q_push,
   output item_type              q_item
);

   logic [SLOT_NUM_W-1:0] slot;

   assign slot       = req_tdata[SLOT_NUM_W-1:0];
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // The range check is done here so the back end only has to look at the
   // free flag of slots that exist.
   always_comb begin
      q_item.op       = op_type'(req_tuser);
      q_item.slot     = slot;
      q_item.in_range = ({1'b0, slot} < (SLOT_NUM_W+1)'(count));
   end

endmodule

>>> rtl/lfsa_queue.sv
// Two-entry queue that decouples the request front end from the list back end.
// Depends on lfsa_pkg.
module lfsa_queue import lfsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output item_type  head_item
);

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);

   item_type               entry_ff [QDEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         fill_ff, fill_in;

   assign full      = (fill_ff == (PTR_W+1)'(QDEPTH));
   assign valid     = (fill_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = (PTR_W+1)'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = (PTR_W+1)'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/lfsa_back.sv
// List back end: keeps the free-list head, the fresh-slot mark and the link/flag
// memory, executes one request at a time and holds the response register.
// Depends on lfsa_pkg and lfsa_ram.
module lfsa_back import lfsa_pkg::*; #(
   parameter int LIST_DEPTH  = 256,
   parameter int IDX_W       = 8,
   parameter int HEAD_W      = 9,
   parameter int CHUNK_BYTES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rebuild,
   input  logic [HEAD_W-1:0]     count,
   input  logic [ADDR_W-1:0]     base,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,   // [7:0] granted_slot, [55:8] slot_address
   output logic [1:0]            rsp_tuser    // [1:0] status
);

   localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
   localparam logic [CHUNK_W-1:0] CHUNK_VAL = CHUNK_W'(CHUNK_BYTES);
   localparam int PROD_W  = HEAD_W + CHUNK_W;
   localparam int ENTRY_W = 1 + HEAD_W;   // {free flag, next link}

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_LOOK = 3'b010,
      BK_EXEC = 3'b100
   } back_state_type;

   back_state_type         state_ff, state_in;
   item_type               cur_ff;
   logic [HEAD_W-1:0]      head_ff, head_in;
   logic [HEAD_W-1:0]      bump_ff, bump_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff, status_in;
   logic [GRANT_W-1:0]     rsp_grant_ff, grant_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, addr_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]     ram_wdata;
   logic [IDX_W-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]     ram_rdata;

   logic                   commit;
   logic                   empty;
   logic                   fresh_alloc;
   logic                   slot_free;
   logic                   rd_flag;
   logic [HEAD_W-1:0]      rd_link;
   logic [HEAD_W-1:0]      cur_slot;

   lfsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LIST_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (q_pop),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign q_pop     = (state_ff == BK_IDLE) && q_valid;
   assign ram_raddr = (q_item.op == OP_ALLOC) ? head_ff[IDX_W-1:0]
                                              : q_item.slot[IDX_W-1:0];

   assign rd_flag  = ram_rdata[ENTRY_W-1];
   assign rd_link  = ram_rdata[HEAD_W-1:0];
   assign cur_slot = HEAD_W'(cur_ff.slot);

   assign commit      = (state_ff == BK_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign empty       = (head_ff >= count);
   // Slots at or above the fresh mark have never left the list since the
   // last rebuild: they are free and their link is simply the next id.
   assign fresh_alloc = (head_ff >= bump_ff);
   assign slot_free   = (cur_ff.slot >= SLOT_NUM_W'(bump_ff)) || rd_flag;

   assign prod_in = PROD_W'(head_ff) * PROD_W'(CHUNK_VAL);

   always_comb begin
      unique case (state_ff)
         BK_IDLE: state_in = q_pop ? BK_LOOK : BK_IDLE;
         BK_LOOK: state_in = BK_EXEC;
         BK_EXEC: state_in = commit ? BK_IDLE : BK_EXEC;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      head_in   = head_ff;
      bump_in   = bump_ff;
      ram_we    = 1'b0;
      ram_waddr = head_ff[IDX_W-1:0];
      ram_wdata = {1'b0, head_ff};
      status_in = ST_IGNORED;
      grant_in  = '0;
      addr_in   = '0;
      if (cur_ff.op == OP_ALLOC) begin
         if (empty) begin
            status_in = ST_NONE_FREE;
         end else begin
            status_in = ST_ALLOCATED;
            grant_in  = GRANT_W'(head_ff);
            addr_in   = base + ADDR_W'(prod_ff);
            ram_we    = commit;
            if (fresh_alloc) begin
               head_in = HEAD_W'(head_ff + 1'b1);
               bump_in = HEAD_W'(bump_ff + 1'b1);
            end else begin
               head_in = rd_link;
            end
         end
      end else if (cur_ff.in_range && !slot_free) begin
         status_in = ST_FREED;
         ram_we    = commit;
         ram_waddr = cur_ff.slot[IDX_W-1:0];
         ram_wdata = {1'b1, head_ff};
         head_in   = cur_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rebuild) begin
            head_ff <= '0;
            bump_ff <= '0;
         end else if (commit) begin
            head_ff <= head_in;
            bump_ff <= bump_in;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (state_ff == BK_LOOK) begin
         prod_ff <= prod_in;
      end
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_grant_ff  <= grant_in;
         rsp_addr_ff   <= addr_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_addr_ff, rsp_grant_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= count)
      else $error("free-list head beyond the slot count");

   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= count)
      else $error("fresh-slot mark beyond the slot count");

   a_alloc_moves_head: assert property (@(posedge clock) disable iff (reset)
      commit && cur_ff.op == OP_ALLOC && !empty |=> head_ff != $past(head_ff))
      else $error("allocation left the head in place");
`endif

endmodule

>>> rtl/lifo_free_list_slot_allocator.sv
// Top level of the LIFO free-list slot allocator.
// Depends on lfsa_pkg, lfsa_front, lfsa_queue and lfsa_back (with lfsa_ram).
//
// The block hands out and takes back fixed-size slots of a shared region.
// A request beat carries the operation in req_tuser (0 allocate, 1 free) and
// the slot number in req_tdata; every request gives exactly one response beat
// with the status in rsp_tuser and the granted slot and its byte address
// (base_address + slot * CHUNK_BYTES, wrapped to 48 bits) in rsp_tdata.
// Freed slots go back on top of the list, so the most recently freed slot is
// the next one granted. Out-of-range and double frees are reported and change
// nothing. Writing slots_in_use (a value of zero acts as one, a value above
// MAX_SLOTS acts as MAX_SLOTS) rebuilds the list: no clearing pass is
// needed, because a fresh-slot mark tracks which slots have never been
// handed out since the rebuild, and only entries below that mark are ever
// taken from the link memory. A request passes three back-end states
// (queue pop and memory read, read data and address multiply, then
// commit), and the back end takes no new request until the last one has
// committed, since each request must see the registered read of the
// link/flag memory before it updates the list. On its way to rsp_tvalid a
// request passes the queue entry, cur_ff and the response register. The
// front end keeps taking requests into a two-entry queue, until it is full,
// while a response waits in its output register.
module lifo_free_list_slot_allocator import lfsa_pkg::*; #(
   parameter int MAX_SLOTS   = 256,
   parameter int CHUNK_BYTES = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // [8:0] slot_number
   input  logic                     req_tuser,   // [0] operation
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [55:0]              rsp_tdata,   // [7:0] granted_slot, [55:8] slot_address
   output logic [1:0]               rsp_tuser,   // [1:0] status
   input  logic                     csr_we,
   input  logic [0:0]               csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   // The slot count register is nine bits wide, so no more than 511 slots
   // can ever be in use, whatever MAX_SLOTS says.
   localparam int LIST_DEPTH = (MAX_SLOTS < 511) ? MAX_SLOTS : 511;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int HEAD_W     = $clog2(LIST_DEPTH + 1);
   localparam logic [COUNT_W:0]   DEPTH_LIM   = (COUNT_W+1)'(LIST_DEPTH);
   localparam logic [COUNT_W-1:0] RESET_SLOTS = COUNT_W'(256);

   logic [HEAD_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]      base_ff;
   logic [COUNT_W-1:0]     count_raw;
   logic [COUNT_W:0]       count_clamped;
   logic                   rebuild;

   logic                   q_full;
   logic                   q_push;
   item_type               q_push_item;
   logic                   q_valid;
   logic                   q_pop;
   item_type               q_head_item;

   // The effective count is clamped once, when it is written, so the rest of
   // the block only ever sees a count between one and the list depth.
   assign count_raw = reset ? RESET_SLOTS : csr_wdata[COUNT_W-1:0];

   always_comb begin
      count_clamped = {1'b0, count_raw};
      if (count_raw == '0) begin
         count_clamped = (COUNT_W+1)'(1);
      end else if (count_clamped > DEPTH_LIM) begin
         count_clamped = DEPTH_LIM;
      end
      count_in = HEAD_W'(count_clamped);
   end

   assign rebuild = csr_we && (csr_index_type'(csr_index) == REG_SLOTS_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= count_in;
         base_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_SLOTS_IN_USE: count_ff <= count_in;
            REG_BASE_ADDRESS: base_ff  <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   lfsa_front #(
      .HEAD_W (HEAD_W)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .count      (count_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   lfsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_item (q_head_item)
   );

   lfsa_back #(
      .LIST_DEPTH  (LIST_DEPTH),
      .IDX_W       (IDX_W),
      .HEAD_W      (HEAD_W),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .rebuild    (rebuild),
      .count      (count_ff),
      .base       (base_ff),
      .q_valid    (q_valid),
      .q_item     (q_head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
